[rtl/ssp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  typedef enum logic [1:0] {
    REQ_SET_GOAL = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_RAW      = 2'd2,
    REQ_INIT     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_ANGLE_OFFSET    = 3'd0,
    CFG_REST_ANGLE      = 3'd1,
    CFG_PULSE_SLOPE     = 3'd2,
    CFG_PULSE_INTERCEPT = 3'd3,
    CFG_REACH_THRESHOLD = 3'd4,
    CFG_WAIT_MS         = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // step = (wait_ms * slew_speed + 500) / 1000, bit-serial restoring divide
  localparam int DIVIDEND_W  = 24;
  localparam int STEP_W      = 15;
  localparam int REM_W       = 10;
  localparam int DIV_CNT_W   = 5;
  localparam logic [REM_W:0]        STEP_DIVISOR = 11'd1000;
  localparam logic [DIVIDEND_W-1:0] STEP_ROUND   = 24'd500;

endpackage

`default_nettype wire

[rtl/servo_slew_pwm_driver.sv]
// Channel  Handshake               Payload
// in       in_valid / in_ready     req_type goal_angle goal_ok move_speed view_mode
//                                  raw_pulse now_ms
// out      out_valid / out_ready   pulse_write pulse_us pose_estimate at_goal
//                                  in_calibration
// cfg      cfg_we                  cfg_index cfg_data
//
// Set goal, raw pulse and non-stepping ticks go from idle straight to the output state.
// Initialize and snapping ticks pass through the bit-serial pulse multiplier;
// a stepping tick first runs the bit-serial divide by 1000 and then the
// multiplier.
// Synchronous reset; one item at a time, taken only while idle. A result held
// in the output register stalls completion of the following item only.
`timescale 1ns / 1ps
`default_nettype none

module servo_slew_pwm_driver #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     req_type,
  input  wire logic signed [15:0]             goal_angle,
  input  wire logic                           goal_ok,
  input  wire logic [15:0]                    move_speed,
  input  wire logic                           view_mode,
  input  wire logic [15:0]                    raw_pulse,
  input  wire logic [31:0]                    now_ms,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                pulse_write,
  output logic [15:0]                         pulse_us,
  output logic signed [15:0]                  pose_estimate,
  output logic                                at_goal,
  output logic                                in_calibration
);
  import ssp_pkg::*;

  localparam int W = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 2;
  localparam logic signed [W-1:0] AMAX_W =
    {{(W-ANGLE_BITS+1){1'b0}}, {(ANGLE_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] AMIN_W =
    {{(W-ANGLE_BITS+1){1'b1}}, {(ANGLE_BITS-1){1'b0}}};
  localparam logic signed [W-1:0] PMAX_W = {{(W-15){1'b0}}, {15{1'b1}}};
  localparam logic signed [W-1:0] PMIN_W = {{(W-15){1'b1}}, {15{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  function automatic logic [ANGLE_BITS-1:0] sat_angle(input logic signed [W-1:0] v);
    logic [ANGLE_BITS-1:0] r;
    if (v > AMAX_W) begin
      r = AMAX_W[ANGLE_BITS-1:0];
    end else if (v < AMIN_W) begin
      r = AMIN_W[ANGLE_BITS-1:0];
    end else begin
      r = v[ANGLE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] sx16(input logic [15:0] v);
    return {{(W-16){v[15]}}, v};
  endfunction

  function automatic logic signed [W-1:0] sxa(input logic [ANGLE_BITS-1:0] v);
    return {{(W-ANGLE_BITS){v[ANGLE_BITS-1]}}, v};
  endfunction

  logic [15:0] angle_offset;
  logic [15:0] rest_angle;
  logic [31:0] pulse_slope;
  logic [15:0] pulse_intercept;
  logic [15:0] reach_threshold;
  logic [7:0]  wait_ms;

  state_t                state;
  logic [ANGLE_BITS-1:0] current_angle;
  logic [ANGLE_BITS-1:0] target_angle;
  logic [15:0]           slew_speed;
  logic                  paced_mode;
  logic                  calibrating_flag;
  logic [31:0]           last_step_ms;
  logic                  res_write;
  logic [15:0]           res_pulse;
  logic                  div_start;
  logic                  mul_start;
  logic                  div_done;
  logic                  mul_done;
  logic [STEP_W-1:0]     step;
  logic [15:0]           mul_pulse;

  logic signed [W-1:0]   diff;
  logic signed [W-1:0]   abs_diff;
  logic                  near;
  logic                  tick_go;
  logic [ANGLE_BITS-1:0] goal_sat;
  logic [ANGLE_BITS-1:0] rest_sat;
  logic [ANGLE_BITS-1:0] step_sat;
  logic signed [W-1:0]   step_x;
  logic signed [W-1:0]   pose_diff;
  logic [15:0]           pose_sat;
  logic [DIVIDEND_W-1:0] step_num;
  logic [31:0]           since;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset    <= '0;
      rest_angle      <= '0;
      pulse_slope     <= 32'd5689;
      pulse_intercept <= 16'd500;
      reach_threshold <= 16'd128;
      wait_ms         <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_OFFSET:    angle_offset    <= cfg_data[15:0];
        CFG_REST_ANGLE:      rest_angle      <= cfg_data[15:0];
        CFG_PULSE_SLOPE:     pulse_slope     <= cfg_data;
        CFG_PULSE_INTERCEPT: pulse_intercept <= cfg_data[15:0];
        CFG_REACH_THRESHOLD: reach_threshold <= cfg_data[15:0];
        CFG_WAIT_MS:         wait_ms         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign diff      = sxa(current_angle) - sxa(target_angle);
  assign abs_diff  = diff[W-1] ? -diff : diff;
  assign near      = abs_diff < {{(W-16){1'b0}}, reach_threshold};
  assign since     = now_ms - last_step_ms;
  assign tick_go   = !calibrating_flag && ((since > {24'd0, wait_ms}) || !paced_mode);
  assign goal_sat  = sat_angle(sx16(goal_angle) + sx16(angle_offset));
  assign rest_sat  = sat_angle(sx16(rest_angle) + sx16(angle_offset));
  assign step_x    = {{(W-STEP_W){1'b0}}, step};
  // goal below current angle steps downward
  assign step_sat  = sat_angle((!diff[W-1] && (diff != '0)) ?
                               sxa(current_angle) - step_x : sxa(current_angle) + step_x);
  assign pose_diff = sxa(current_angle) - sx16(angle_offset);
  assign pose_sat  = (pose_diff > PMAX_W) ? PMAX_W[15:0] :
                     (pose_diff < PMIN_W) ? PMIN_W[15:0] : pose_diff[15:0];
  assign step_num  = DIVIDEND_W'(wait_ms) * DIVIDEND_W'(slew_speed) + STEP_ROUND;
  assign in_ready  = state == S_IDLE;

  ssp_step_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (step_num),
    .done     (div_done),
    .quotient (step)
  );

  ssp_pulse_mul #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .angle     (current_angle),
    .slope     (pulse_slope),
    .intercept (pulse_intercept),
    .done      (mul_done),
    .pulse     (mul_pulse)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      current_angle    <= '0;
      target_angle     <= '0;
      slew_speed       <= '0;
      paced_mode       <= 1'b0;
      calibrating_flag <= 1'b0;
      last_step_ms     <= '0;
      div_start        <= 1'b0;
      mul_start        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      div_start <= 1'b0;
      mul_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_write <= 1'b0;
            res_pulse <= '0;
            case (req_type)
              REQ_SET_GOAL: begin
                calibrating_flag <= 1'b0;
                paced_mode       <= view_mode;
                if (goal_ok) begin
                  target_angle <= goal_sat;
                  slew_speed   <= move_speed;
                end
                state <= S_OUT;
              end
              REQ_TICK: begin
                if (tick_go) begin
                  last_step_ms <= now_ms;
                  if (near) begin
                    current_angle <= target_angle;
                    mul_start     <= 1'b1;
                    state         <= S_MUL;
                  end else begin
                    div_start <= 1'b1;
                    state     <= S_DIV;
                  end
                end else begin
                  state <= S_OUT;
                end
              end
              REQ_RAW: begin
                res_write        <= 1'b1;
                res_pulse        <= raw_pulse;
                calibrating_flag <= 1'b1;
                state            <= S_OUT;
              end
              REQ_INIT: begin
                target_angle  <= rest_sat;
                current_angle <= rest_sat;
                last_step_ms  <= now_ms;
                mul_start     <= 1'b1;
                state         <= S_MUL;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            current_angle <= step_sat;
            mul_start     <= 1'b1;
            state         <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            res_write <= 1'b1;
            res_pulse <= mul_pulse;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            pulse_write    <= res_write;
            pulse_us       <= res_pulse;
            pose_estimate  <= pose_sat;
            at_goal        <= near;
            in_calibration <= calibrating_flag;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL)
    else $error("multiplier finished outside the multiply state");

  a_no_pulse_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pulse_write |-> pulse_us == 16'd0)
    else $error("pulse width non-zero on a result without a pulse");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken before the first item finished");
`endif

endmodule

`default_nettype wire

[rtl/ssp_step_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssp_step_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [ssp_pkg::DIVIDEND_W-1:0] dividend,
  output logic                                done,
  output logic [ssp_pkg::STEP_W-1:0]          quotient
);
  import ssp_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [REM_W-1:0]      rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [REM_W:0]        trial;
  logic                  ge;
  logic [REM_W:0]        trial_sub;

  assign trial     = {rem, quo[DIVIDEND_W-1]};
  assign ge        = trial >= STEP_DIVISOR;
  assign trial_sub = trial - STEP_DIVISOR;
  assign quotient  = quo[STEP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ssp_pulse_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssp_pulse_mul #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [ANGLE_BITS-1:0] angle,
  input  wire logic [31:0]           slope,
  input  wire logic [15:0]           intercept,
  output logic                       done,
  output logic [15:0]                pulse
);
  import ssp_pkg::*;

  localparam int CNT_W = (ANGLE_BITS > 1) ? $clog2(ANGLE_BITS) : 1;
  localparam int PW    = ANGLE_BITS + 33;

  logic                     busy;
  logic                     rnd;
  logic [CNT_W-1:0]         cnt;
  logic signed [32:0]       acc;
  logic [ANGLE_BITS-1:0]    lo;
  logic                     last;
  logic signed [32:0]       slope_x;
  logic signed [32:0]       addend;
  logic signed [32:0]       sum;
  logic [PW-1:0]            prod;
  logic [PW-1:0]            biased;

  assign last    = cnt == CNT_W'(ANGLE_BITS - 1);
  assign slope_x = {slope[31], slope};
  assign addend  = lo[0] ? (last ? -slope_x : slope_x) : '0;
  assign sum     = acc + addend;
  assign prod    = {acc, lo};
  // intercept * 65536 plus the rounding half, in one add
  assign biased  = prod + {{(PW-32){intercept[15]}}, intercept, 16'h8000};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      rnd  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        lo   <= angle;
      end else if (busy) begin
        acc <= sum >>> 1;
        lo  <= {sum[0], lo[ANGLE_BITS-1:1]};
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          rnd  <= 1'b1;
        end
      end
      if (rnd) begin
        done <= 1'b1;
        if (biased[PW-1]) begin
          pulse <= '0;
        end else if (|biased[PW-2:32]) begin
          pulse <= 16'hFFFF;
        end else begin
          pulse <= biased[31:16];
        end
      end
    end
  end

endmodule

`default_nettype wire

[sim/servo_slew_pwm_driver_tb.sv]
`timescale 1ns / 1ps

module servo_slew_pwm_driver_tb;
  import ssp_pkg::*;

  localparam int ANGLE_BITS   = 16;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    req_t               kind;
    logic signed [15:0] goal_angle;
    logic               goal_ok;
    logic [15:0]        move_speed;
    logic               view_mode;
    logic [15:0]        raw_pulse;
    logic [31:0]        now_ms;
  } servo_req_t;

  typedef struct packed {
    logic               pulse_write;
    logic [15:0]        pulse_us;
    logic signed [15:0] pose_estimate;
    logic               at_goal;
    logic               in_calibration;
  } servo_resp_t;

  typedef struct {
    logic signed [15:0] angle_offset;
    logic signed [15:0] rest_angle;
    logic signed [31:0] pulse_slope;
    logic signed [15:0] pulse_intercept;
    logic [15:0]        reach_threshold;
    logic [7:0]         wait_ms;
  } servo_settings_t;

  class servo_scoreboard;
    longint ofs, rest, slope_q16, intercept_us, snap_dist, pace_ms;
    longint pos, goal, rate;
    bit paced, calibrating;
    logic [31:0] last_ms;
    servo_resp_t expected_responses[$];
    int errors;
    int checked;

    function new();
      ofs = 0;
      rest = 0;
      slope_q16 = 5689;
      intercept_us = 500;
      snap_dist = 128;
      pace_ms = 10;
      pos = 0;
      goal = 0;
      rate = 0;
      paced = 1'b0;
      calibrating = 1'b0;
      last_ms = '0;
      errors = 0;
      checked = 0;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint clamp_angle(longint v);
      longint half;
      half = longint'(1) << (ANGLE_BITS - 1);
      return clamp(v, -half, half - 1);
    endfunction

    function bit near_goal();
      longint d;
      d = pos - goal;
      if (d < 0) d = -d;
      return d < snap_dist;
    endfunction

    // Q16 map, rounded half away from zero
    function longint pulse_for(longint angle);
      longint acc, mag, rounded;
      acc = angle * slope_q16 + intercept_us * 65536;
      if (acc >= 0) begin
        rounded = (acc + 32768) >>> 16;
      end else begin
        mag = -acc;
        rounded = -((mag + 32768) >>> 16);
      end
      return clamp(rounded, 0, 65535);
    endfunction

    function void apply_setting(cfg_idx_t idx, logic [31:0] value);
      case (idx)
        CFG_ANGLE_OFFSET:    ofs = longint'($signed(value[15:0]));
        CFG_REST_ANGLE:      rest = longint'($signed(value[15:0]));
        CFG_PULSE_SLOPE:     slope_q16 = longint'($signed(value));
        CFG_PULSE_INTERCEPT: intercept_us = longint'($signed(value[15:0]));
        CFG_REACH_THRESHOLD: snap_dist = longint'(value[15:0]);
        CFG_WAIT_MS:         pace_ms = longint'(value[7:0]);
        default: ;
      endcase
    endfunction

    function servo_resp_t predict_response(servo_req_t r);
      servo_resp_t o;
      longint stride;
      logic [31:0] elapsed;
      o = '0;
      elapsed = r.now_ms - last_ms;
      case (r.kind)
        REQ_SET_GOAL: begin
          calibrating = 1'b0;
          paced = r.view_mode;
          if (r.goal_ok) begin
            goal = clamp_angle(longint'(r.goal_angle) + ofs);
            rate = longint'(r.move_speed);
          end
        end
        REQ_TICK: begin
          if (!calibrating && (elapsed > 32'(pace_ms) || !paced)) begin
            if (!near_goal()) begin
              stride = (pace_ms * rate + 500) / 1000;
              if (goal - pos < 0) stride = -stride;
              pos = clamp_angle(pos + stride);
            end else begin
              pos = goal;
            end
            o.pulse_write = 1'b1;
            o.pulse_us = 16'(pulse_for(pos));
            last_ms = r.now_ms;
          end
        end
        REQ_RAW: begin
          o.pulse_write = 1'b1;
          o.pulse_us = r.raw_pulse;
          calibrating = 1'b1;
        end
        default: begin
          goal = clamp_angle(rest + ofs);
          pos = goal;
          o.pulse_write = 1'b1;
          o.pulse_us = 16'(pulse_for(pos));
          last_ms = r.now_ms;
        end
      endcase
      o.pose_estimate = 16'(clamp(pos - ofs, -32768, 32767));
      o.at_goal = near_goal();
      o.in_calibration = calibrating;
      return o;
    endfunction

    function void note_request(servo_req_t r);
      expected_responses.push_back(predict_response(r));
    endfunction

    task compare_field(string name, longint got, longint want);
      if (got != want)
        report_mismatch($sformatf("response %0d %s got %0d want %0d", checked, name, got,
                                  want));
    endtask

    task check_response(servo_resp_t got);
      servo_resp_t want;
      if (expected_responses.size() == 0) begin
        report_mismatch("response with no request outstanding");
        return;
      end
      want = expected_responses.pop_front();
      compare_field("pulse_write", got.pulse_write, want.pulse_write);
      compare_field("pulse_us", got.pulse_us, want.pulse_us);
      compare_field("pose_estimate", got.pose_estimate, want.pose_estimate);
      compare_field("at_goal", got.at_goal, want.at_goal);
      compare_field("in_calibration", got.in_calibration, want.in_calibration);
      checked++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            req_type = '0;
  logic signed [15:0]    goal_angle = '0;
  logic                  goal_ok = 1'b0;
  logic [15:0]           move_speed = '0;
  logic                  view_mode = 1'b0;
  logic [15:0]           raw_pulse = '0;
  logic [31:0]           now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  pulse_write;
  logic [15:0]           pulse_us;
  logic signed [15:0]    pose_estimate;
  logic                  at_goal;
  logic                  in_calibration;

  int          send_idle_pct = 10;
  int          recv_idle_pct = 57;
  logic [31:0] ms_clock = '0;

  servo_scoreboard sb = new();

  servo_slew_pwm_driver #(.ANGLE_BITS(ANGLE_BITS)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_response(servo_resp_t'{pulse_write, pulse_us, pose_estimate, at_goal,
                                        in_calibration});
      if (in_valid && in_ready)
        sb.note_request(servo_req_t'{req_t'(req_type), goal_angle, goal_ok, move_speed,
                                     view_mode, raw_pulse, now_ms});
    end
  end

  initial begin : receiver
    int cycles_run;
    cycles_run = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cycles_run++;
      if (cycles_run == 3000 || cycles_run == 40000) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic drive_item(input servo_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= r.kind;
    goal_angle <= r.goal_angle;
    goal_ok    <= r.goal_ok;
    move_speed <= r.move_speed;
    view_mode  <= r.view_mode;
    raw_pulse  <= r.raw_pulse;
    now_ms     <= r.now_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] fill_upper(input logic [31:0] low, input int width);
    logic [31:0] mask;
    mask = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
    return ($urandom() & ~mask) | (low & mask);
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.apply_setting(idx, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic quiesce_and_configure(input servo_settings_t s);
    wait_drained();
    write_reg(CFG_ANGLE_OFFSET, fill_upper({16'd0, s.angle_offset}, 16));
    write_reg(CFG_REST_ANGLE, fill_upper({16'd0, s.rest_angle}, 16));
    write_reg(CFG_PULSE_SLOPE, s.pulse_slope);
    write_reg(CFG_PULSE_INTERCEPT, fill_upper({16'd0, s.pulse_intercept}, 16));
    write_reg(CFG_REACH_THRESHOLD, fill_upper({16'd0, s.reach_threshold}, 16));
    write_reg(CFG_WAIT_MS, fill_upper({24'd0, s.wait_ms}, 8));
    cfg_we <= 1'b0;
  endtask

  function automatic servo_settings_t random_settings(input bit moderate);
    servo_settings_t s;
    if (moderate) begin
      s.angle_offset    = 16'($urandom_range(0, 4000) - 2000);
      s.rest_angle      = 16'($urandom_range(0, 16000) - 8000);
      s.pulse_slope     = 32'($urandom_range(2000, 9000));
      if ($urandom_range(0, 3) == 0) s.pulse_slope = -s.pulse_slope;
      s.pulse_intercept = 16'($urandom_range(0, 3000));
      s.reach_threshold = 16'($urandom_range(0, 600));
      s.wait_ms         = 8'($urandom_range(1, 40));
    end else begin
      s.angle_offset    = 16'($urandom());
      s.rest_angle      = 16'($urandom());
      s.pulse_slope     = $urandom();
      s.pulse_intercept = 16'($urandom());
      s.reach_threshold = 16'($urandom());
      s.wait_ms         = 8'($urandom());
    end
    return s;
  endfunction

  function automatic servo_req_t random_req(input req_t kind);
    servo_req_t r;
    r.kind       = kind;
    r.goal_angle = 16'($urandom());
    r.goal_ok    = 1'($urandom());
    r.move_speed = 16'($urandom());
    r.view_mode  = 1'($urandom());
    r.raw_pulse  = 16'($urandom());
    r.now_ms     = $urandom();
    return r;
  endfunction

  function automatic servo_req_t directed_req(input req_t kind, input int goal, input bit ok,
                                              input int speed, input bit view, input int raw,
                                              input logic [31:0] stamp);
    servo_req_t r;
    r.kind       = kind;
    r.goal_angle = 16'(goal);
    r.goal_ok    = ok;
    r.move_speed = 16'(speed);
    r.view_mode  = view;
    r.raw_pulse  = 16'(raw);
    r.now_ms     = stamp;
    return r;
  endfunction

  task automatic send_tick();
    servo_req_t r;
    r = random_req(REQ_TICK);
    ms_clock = ms_clock + $urandom_range(0, 32'(2 * sb.pace_ms + 3));
    r.now_ms = ms_clock;
    drive_item(r);
  endtask

  // mostly goal-then-ticks motion, some calibration detours, some noise
  task automatic run_random(input int count);
    int sent;
    int pick;
    servo_req_t r;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 3) == 0) begin
          r = random_req(REQ_INIT);
          r.now_ms = ms_clock;
          drive_item(r);
          sent++;
        end
        r = random_req(REQ_SET_GOAL);
        r.goal_ok = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) != 0) r.goal_angle = 16'($urandom_range(0, 24000) - 12000);
        case ($urandom_range(0, 3))
          0: r.move_speed = 16'($urandom_range(0, 500));
          1: ;
          default: r.move_speed = 16'($urandom_range(500, 20000));
        endcase
        drive_item(r);
        sent++;
        repeat ($urandom_range(1, 12)) begin
          send_tick();
          sent++;
        end
      end else if (pick < 85) begin
        drive_item(random_req(REQ_RAW));
        sent++;
        repeat ($urandom_range(1, 3)) begin
          send_tick();
          sent++;
        end
      end else begin
        r = random_req(req_t'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 0) ms_clock = r.now_ms;
        else r.now_ms = ms_clock;
        drive_item(r);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    quiesce_and_configure('{16'sd0, 16'sd0, 32'sd5689, 16'sd500, 16'd128, 8'd10});

    drive_item(directed_req(REQ_INIT, 0, 1'b0, 0, 1'b0, 0, 32'd0));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd1));
    drive_item(directed_req(REQ_SET_GOAL, 32767, 1'b1, 65535, 1'b0, 0, 32'd1));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd2));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd3));
    // invalid goal: keeps goal and speed, still latches pacing
    drive_item(directed_req(REQ_SET_GOAL, -32768, 1'b0, 0, 1'b1, 0, 32'd3));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd5));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd14));
    drive_item(directed_req(REQ_SET_GOAL, -32768, 1'b1, 1, 1'b1, 0, 32'd14));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd30));
    drive_item(directed_req(REQ_SET_GOAL, -32768, 1'b1, 65535, 1'b0, 0, 32'd30));
    repeat (6) drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd31));
    // calibration blocks ticks until the next goal
    drive_item(directed_req(REQ_RAW, 0, 1'b0, 0, 1'b0, 65535, 32'd40));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd100));
    drive_item(directed_req(REQ_INIT, 0, 1'b0, 0, 1'b0, 0, 32'd101));
    drive_item(directed_req(REQ_RAW, 0, 1'b0, 0, 1'b0, 0, 32'd102));
    drive_item(directed_req(REQ_SET_GOAL, 0, 1'b1, 65535, 1'b0, 0, 32'd103));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'hFFFF_FFFF));
    // time stamp wrap under pacing
    drive_item(directed_req(REQ_SET_GOAL, 100, 1'b1, 1000, 1'b1, 0, 32'd0));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd5));
    drive_item(directed_req(REQ_TICK, 0, 1'b0, 0, 1'b0, 0, 32'd10));

    ms_clock = 32'hFFFF_FC00;
    run_random(350);
    quiesce_and_configure('{16'sh8000, 16'sh7FFF, 32'sh7FFF_FFFF, 16'sh8000, 16'd0, 8'd0});
    run_random(200);

    send_idle_pct = 57;
    recv_idle_pct = 10;
    quiesce_and_configure(random_settings(1'b1));
    run_random(350);
    quiesce_and_configure('{16'sh7FFF, 16'sh8000, 32'sh8000_0000, 16'sh7FFF, 16'hFFFF, 8'hFF});
    run_random(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiesce_and_configure(random_settings(1'b0));
    run_random(350);
    quiesce_and_configure(random_settings(1'b1));
    run_random(500);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
